>>> rtl/keyed_sine_tone_envelope_macros.svh
// Assertion macros for the keyed sine tone envelope block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KEYED_SINE_TONE_ENVELOPE_MACROS_SVH
`define KEYED_SINE_TONE_ENVELOPE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define STSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define STSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/stse_pkg.sv
// Shared constants, types and tables for the keyed sine tone envelope.
// No dependencies; imported by every module of the block except stse_ram.
package stse_pkg;

	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS    = 16;

	localparam int TABLE_LEN  = 1 << SINE_ADDR_BITS;
	localparam int MAG_BITS   = SAMPLE_BITS - 1;
	localparam int AMP_BITS   = 16;
	localparam int STEP_BITS  = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [MAG_BITS-1:0]    SAMPLE_MAX = {MAG_BITS{1'b1}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {MAG_BITS{1'b0}}};
	localparam logic [AMP_BITS-1:0]    FULL_SCALE = 16'd32768;

	localparam logic [STEP_BITS-1:0] PHASE_STEP_RST = 32'd53687091;
	localparam logic [AMP_BITS-1:0]  VOLUME_RST     = 16'd16384;
	localparam logic [AMP_BITS-1:0]  RAMP_STEP_RST  = 16'd114;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_VOLUME     = 2'd1,
		REG_RAMP_STEP  = 2'd2
	} cfg_reg_t;

	// table build: Q30 Taylor series of sin, terms to x^15
	localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
	localparam int          TAYLOR_TERMS = 7;
	localparam int          TERM_IDX_BITS = 3;
	localparam int          SCALE_BITS   = 32 + SAMPLE_BITS;
	localparam logic [SCALE_BITS-1:0] ROUND_Q30 = SCALE_BITS'(1) << 29;
	localparam logic [33:0] RCP_SCALE = 34'd1 << 33;

	localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210
	};
	localparam logic [30:0] TAYLOR_RCP [TAYLOR_TERMS] = '{
		31'(RCP_SCALE / 6),   31'(RCP_SCALE / 20),  31'(RCP_SCALE / 42),
		31'(RCP_SCALE / 72),  31'(RCP_SCALE / 110), 31'(RCP_SCALE / 156),
		31'(RCP_SCALE / 210)
	};

	typedef enum logic [3:0] {
		FL_X,
		FL_X2,
		FL_MUL,
		FL_RCP,
		FL_COR,
		FL_DIFF,
		FL_SCALE,
		FL_WRITE,
		FL_DONE
	} fill_state_t;

	typedef struct packed {
		logic [STEP_BITS-1:0] phase_step;
		logic [AMP_BITS-1:0]  volume;
		logic [AMP_BITS-1:0]  ramp_step;
	} cfg_t;

	typedef struct packed {
		logic                      en;
		logic [SINE_ADDR_BITS-1:0] addr;
		logic [MAG_BITS-1:0]       data;
	} tbl_wr_t;

	typedef struct packed {
		logic accept;
		logic load_out;
	} pipe_ctl_t;

endpackage

>>> rtl/stse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/stse_table_fill.sv
// Sequencer that computes the quarter-wave sine magnitudes after reset.
// Depends on stse_pkg; drives the write port of the sine table RAM.
module stse_table_fill (
	input  logic            clk,
	input  logic            arst_n,
	output stse_pkg::tbl_wr_t tbl_wr,
	output logic            done
);
	import stse_pkg::*;

	fill_state_t state_q, state_d;

	logic [SINE_ADDR_BITS-1:0] idx_q;
	logic [TERM_IDX_BITS-1:0]  k_q;
	logic [30:0]               x_q;
	logic [31:0]               x2_q;
	logic [30:0]               term_q;
	logic [31:0]               pos_q;
	logic [31:0]               neg_q;
	logic [62:0]               prod_q;
	logic [30:0]               qe_q;
	logic [31:0]               s_q;
	logic [SCALE_BITS-1:0]     e_raw_q;

	logic [SINE_ADDR_BITS+31:0] x_prod;
	logic [61:0]                sq_prod;
	logic [63:0]                rcp_prod;
	logic [32:0]                p_val;
	logic [38:0]                qd_prod;
	logic [32:0]                rem;
	logic [30:0]                term_new;
	logic [SAMPLE_BITS+1:0]     e_sh;
	logic [MAG_BITS-1:0]        e_cap;
	logic                       last_idx;
	logic                       last_term;

	assign x_prod   = HALF_PI_Q30 * (SINE_ADDR_BITS+1)'({idx_q, 1'b1});
	assign sq_prod  = x_q * x_q;
	assign p_val    = prod_q[62:30];
	assign rcp_prod = p_val * TAYLOR_RCP[k_q];
	assign qd_prod  = qe_q * TAYLOR_DIV[k_q];
	assign rem      = p_val - qd_prod[32:0];
	assign term_new = (rem >= 33'(TAYLOR_DIV[k_q])) ? qe_q + 31'd1 : qe_q;
	assign e_sh     = e_raw_q[SCALE_BITS-1:30];
	assign e_cap    = (e_sh > (SAMPLE_BITS+2)'(SAMPLE_MAX)) ? SAMPLE_MAX : e_sh[MAG_BITS-1:0];
	assign last_idx  = (idx_q == SINE_ADDR_BITS'(TABLE_LEN - 1));
	assign last_term = (k_q == TERM_IDX_BITS'(TAYLOR_TERMS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FL_X;
			idx_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FL_X2) begin
				k_q <= '0;
			end else if (state_q == FL_COR && !last_term) begin
				k_q <= k_q + TERM_IDX_BITS'(1);
			end
			if (state_q == FL_WRITE && !last_idx) begin
				idx_q <= idx_q + SINE_ADDR_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FL_X: begin
				x_q <= x_prod[SINE_ADDR_BITS+1 +: 31];
			end
			FL_X2: begin
				x2_q   <= sq_prod[61:30];
				term_q <= x_q;
				pos_q  <= {1'b0, x_q};
				neg_q  <= '0;
			end
			FL_MUL: begin
				prod_q <= term_q * x2_q;
			end
			FL_RCP: begin
				qe_q <= rcp_prod[63:33];
			end
			FL_COR: begin
				term_q <= term_new;
				if (!k_q[0]) begin
					neg_q <= neg_q + {1'b0, term_new};
				end else begin
					pos_q <= pos_q + {1'b0, term_new};
				end
			end
			FL_DIFF: begin
				s_q <= (pos_q > neg_q) ? pos_q - neg_q : '0;
			end
			FL_SCALE: begin
				e_raw_q <= s_q * SAMPLE_MAX + ROUND_Q30;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = idx_q;
		tbl_wr.data = e_cap;
		done        = 1'b0;
		case (state_q)
			FL_X:     state_d = FL_X2;
			FL_X2:    state_d = FL_MUL;
			FL_MUL:   state_d = FL_RCP;
			FL_RCP:   state_d = FL_COR;
			FL_COR:   state_d = last_term ? FL_DIFF : FL_MUL;
			FL_DIFF:  state_d = FL_SCALE;
			FL_SCALE: state_d = FL_WRITE;
			FL_WRITE: begin
				tbl_wr.en = 1'b1;
				state_d   = last_idx ? FL_DONE : FL_X;
			end
			FL_DONE: begin
				done = 1'b1;
			end
			default: begin
				state_d = FL_X;
			end
		endcase
	end

endmodule

>>> rtl/stse_envelope.sv
// Amplitude ramp and phase accumulator state, sine table address generation.
// Depends on stse_pkg.
module stse_envelope (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              key_down,
	input  stse_pkg::cfg_t                    cfg,
	output logic [stse_pkg::SINE_ADDR_BITS-1:0] rd_addr,
	output logic                              neg,
	output logic [stse_pkg::AMP_BITS-1:0]     amp_next
);
	import stse_pkg::*;

	logic [AMP_BITS-1:0]   amp_q;
	logic [PHASE_BITS-1:0] phase_q;

	logic [AMP_BITS-1:0]       vol;
	logic [AMP_BITS-1:0]       target;
	logic [AMP_BITS:0]         up;
	logic [AMP_BITS-1:0]       gap;
	logic [1:0]                quad;
	logic [SINE_ADDR_BITS-1:0] addr;

	assign vol    = (cfg.volume > FULL_SCALE) ? FULL_SCALE : cfg.volume;
	assign target = key_down ? vol : '0;
	assign up     = {1'b0, amp_q} + {1'b0, cfg.ramp_step};
	assign gap    = amp_q - target;
	assign quad   = phase_q[PHASE_BITS-1 -: 2];
	assign addr   = phase_q[PHASE_BITS-3 -: SINE_ADDR_BITS];

	always_comb begin
		if (amp_q < target) begin
			amp_next = (up > {1'b0, target}) ? target : up[AMP_BITS-1:0];
		end else if (amp_q > target) begin
			amp_next = (gap > cfg.ramp_step) ? amp_q - cfg.ramp_step : target;
		end else begin
			amp_next = amp_q;
		end
	end

	assign rd_addr = quad[0] ? ~addr : addr;
	assign neg     = quad[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= '0;
			phase_q <= '0;
		end else if (accept) begin
			amp_q <= amp_next;
			if (amp_next != '0) begin
				phase_q <= phase_q + PHASE_BITS'(cfg.phase_step);
			end
		end
	end

endmodule

>>> rtl/stse_scale.sv
// Sine magnitude times amplitude, sign and output register.
// Depends on stse_pkg; reads the registered sine table data.
module stse_scale (
	input  logic                              clk,
	input  stse_pkg::pipe_ctl_t               ctl,
	input  logic [stse_pkg::MAG_BITS-1:0]     rd_data,
	input  logic                              neg,
	input  logic [stse_pkg::AMP_BITS-1:0]     amp_next,
	output logic signed [stse_pkg::SAMPLE_BITS-1:0] sample,
	output logic [stse_pkg::AMP_BITS-1:0]     level
);
	import stse_pkg::*;

	logic [AMP_BITS-1:0]          amp_s1;
	logic                         neg_s1;
	logic [MAG_BITS+AMP_BITS-1:0] prod;
	logic [SAMPLE_BITS-1:0]       mag;

	assign prod = rd_data * amp_s1;
	assign mag  = {1'b0, prod[15 +: MAG_BITS]};

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			amp_s1 <= amp_next;
			neg_s1 <= neg;
		end
		if (ctl.load_out) begin
			sample <= neg_s1 ? -mag : mag;
			level  <= amp_s1;
		end
	end

endmodule

>>> rtl/keyed_sine_tone_envelope.sv
// Top level of the keyed sine tone envelope: config registers, pipeline control.
// Depends on stse_pkg, stse_table_fill, stse_ram, stse_envelope, stse_scale and
// keyed_sine_tone_envelope_macros.svh.
//
//   channel  signals                            transfer
//   input    in_valid in_ready key_down         in_valid & in_ready
//   output   out_valid out_ready sample level   out_valid & out_ready
//   config   cfg_we cfg_index cfg_data          cfg_we
//
// One item per cycle while the output is not stalled; a result passes through stage one
// and then the output register. The amplitude and phase recurrence closes around its
// own registers; the table read and the multiply form the second stage. After reset
// the sine table is computed into RAM, during which in_ready stays low.
// An output stall holds one result in the output register and one in stage one.
`include "keyed_sine_tone_envelope_macros.svh"

module keyed_sine_tone_envelope (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  key_down,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [stse_pkg::SAMPLE_BITS-1:0] sample,
	output logic [stse_pkg::AMP_BITS-1:0]         level,
	input  logic                                  cfg_we,
	input  logic [stse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [stse_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import stse_pkg::*;

	cfg_t      cfg_q;
	pipe_ctl_t ctl;
	tbl_wr_t   tbl_wr;
	logic      fill_done;
	logic      s1_valid_q;
	logic      out_valid_q;

	logic [SINE_ADDR_BITS-1:0] rd_addr;
	logic [MAG_BITS-1:0]       rd_data;
	logic                      neg;
	logic [AMP_BITS-1:0]       amp_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= PHASE_STEP_RST;
			cfg_q.volume     <= VOLUME_RST;
			cfg_q.ramp_step  <= RAMP_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[STEP_BITS-1:0];
				REG_VOLUME:     cfg_q.volume     <= cfg_data[AMP_BITS-1:0];
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data[AMP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ctl.load_out = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready     = fill_done && (!s1_valid_q || !out_valid_q || out_ready);
	assign ctl.accept   = in_valid && in_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				s1_valid_q <= 1'b1;
			end else if (ctl.load_out) begin
				s1_valid_q <= 1'b0;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	stse_table_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl_wr (tbl_wr),
		.done   (fill_done)
	);

	stse_ram #(
		.WIDTH (MAG_BITS),
		.DEPTH (TABLE_LEN)
	) u_sine_ram (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.data),
		.re    (ctl.accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	stse_envelope u_env (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (ctl.accept),
		.key_down (key_down),
		.cfg      (cfg_q),
		.rd_addr  (rd_addr),
		.neg      (neg),
		.amp_next (amp_next)
	);

	stse_scale u_scale (
		.clk      (clk),
		.ctl      (ctl),
		.rd_data  (rd_data),
		.neg      (neg),
		.amp_next (amp_next),
		.sample   (sample),
		.level    (level)
	);

	`STSE_ASSERT_IMPLY(a_level_range, clk, arst_n, out_valid_q, level <= FULL_SCALE, "level too high")
	`STSE_ASSERT_IMPLY(a_sample_range, clk, arst_n, out_valid_q, sample != SAMPLE_MIN, "sample overflow")
	`STSE_ASSERT_IMPLY(a_silent_zero, clk, arst_n, out_valid_q && level == '0, sample == '0, "silent tick")
	`STSE_ASSERT_NEXT(a_fill_once, clk, arst_n, fill_done, fill_done && !tbl_wr.en, "late table write")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for keyed_sine_tone_envelope: tone samples and envelope level.
// Predicts each result from the key input, the register settings and a locally built
// sine table; depends on stse_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import stse_pkg::*;

	localparam int PH          = PHASE_BITS;
	localparam int AB          = SINE_ADDR_BITS;
	localparam int LIMIT_CYCLES = 400000;
	localparam longint unsigned HALF_PI = 64'd1686629713;
	localparam int unsigned TONE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int unsigned AMP_FULL = 32768;
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [AMP_BITS-1:0]           level;
	} tone_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic key_down = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [AMP_BITS-1:0] level;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	logic in_xfer = 1'b0;
	logic key_pending [$];
	tone_res_t tone_due [$];
	int unsigned sine_rom [TABLE_LEN];
	int sender_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	// local copy of the registers and the envelope/phase state
	logic [31:0] ps_reg = PHASE_STEP_RST;
	int unsigned vol_reg = 32'(VOLUME_RST);
	int unsigned ramp_reg = 32'(RAMP_STEP_RST);
	int unsigned amp_now = 0;
	logic [PH-1:0] phase_now = '0;

	keyed_sine_tone_envelope i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_down  (key_down),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.level     (level),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic tone_res_t next_tone(logic key);
		int unsigned cap;
		int unsigned goal;
		int unsigned up;
		int unsigned mag;
		logic [1:0] quad;
		logic [AB-1:0] addr;
		tone_res_t r;
		cap = (vol_reg > AMP_FULL) ? AMP_FULL : vol_reg;
		goal = key ? cap : 0;
		if (amp_now < goal) begin
			up = amp_now + ramp_reg;
			amp_now = (up > goal) ? goal : up;
		end else if (amp_now > goal) begin
			amp_now = (amp_now - goal > ramp_reg) ? amp_now - ramp_reg : goal;
		end
		r.sample = '0;
		if (amp_now > 0) begin
			quad = phase_now[PH-1 -: 2];
			addr = phase_now[PH-3 -: AB];
			if (quad[0])
				addr = ~addr;
			mag = (sine_rom[addr] * amp_now) >> 15;
			r.sample = quad[1] ? SAMPLE_BITS'(0 - mag) : SAMPLE_BITS'(mag);
			phase_now = phase_now + ps_reg;
		end
		r.level = AMP_BITS'(amp_now);
		return r;
	endfunction

	// drive the input channel
	always @(negedge clk) begin
		logic nv;
		logic nk;
		nv = in_valid;
		nk = key_down;
		if (!in_valid || in_xfer) begin
			nv = 1'b0;
			if (key_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				nv = 1'b1;
				nk = key_pending.pop_front();
			end
		end
		in_valid <= nv;
		key_down <= nk;
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// predict on input transfers, check on output transfers
	always @(posedge clk) begin
		tone_res_t want;
		in_xfer <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				tone_due.push_back(next_tone(key_down));
			if (out_valid && out_ready) begin
				if (tone_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("cycle %0d: unexpected result sample %0d level %0d",
							cycle_cnt, sample, level);
				end else begin
					want = tone_due.pop_front();
					if (want.sample !== sample || want.level !== level) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("cycle %0d: sample exp %0d got %0d, level exp %0d got %0d",
								cycle_cnt, want.sample, sample, want.level, level);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic settle();
		wait (key_pending.size() == 0);
		@(negedge clk);
		wait (!in_valid && tone_due.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_PHASE_STEP: ps_reg = data;
			REG_VOLUME:     vol_reg = 32'(data[AMP_BITS-1:0]);
			REG_RAMP_STEP:  ramp_reg = 32'(data[AMP_BITS-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_keys(logic [31:0] keys, int n);
		for (int i = n - 1; i >= 0; i--)
			key_pending.push_back(keys[i]);
	endtask

	task automatic shuffle_config();
		logic [31:0] ps;
		logic [15:0] vol;
		logic [15:0] ramp;
		case ($urandom_range(3))
			0: ps = $urandom();
			1: ps = $urandom_range(1, 1 << 26);
			2: ps = 32'hFFFF_FFFF - $urandom_range(1 << 20);
			default: ps = (1 << 30) - $urandom_range(1 << 21);
		endcase
		case ($urandom_range(5))
			0: vol = 16'd0;
			1: vol = 16'd32768;
			2: vol = 16'hFFFF;
			3: vol = 16'($urandom_range(16'hFFFF));
			default: vol = 16'($urandom_range(1, 32768));
		endcase
		case ($urandom_range(7))
			0: ramp = 16'd0;
			1: ramp = 16'd1;
			2: ramp = 16'd32768;
			3: ramp = 16'($urandom_range(32769, 16'hFFFF));
			default: ramp = 16'($urandom_range(1, 4096));
		endcase
		write_reg(REG_PHASE_STEP, ps);
		write_reg(REG_VOLUME, {16'($urandom()), vol});
		write_reg(REG_RAMP_STEP, {16'($urandom()), ramp});
		if ($urandom_range(3) == 0)
			write_reg(REG_NONE, $urandom());
	endtask

	// hold each key state for a run; short runs act as key bounce
	task automatic queue_keys(int n);
		int left;
		int run;
		logic k;
		left = n;
		k = 1'($urandom_range(1));
		while (left > 0) begin
			if ($urandom_range(3) == 0)
				run = $urandom_range(1, 3);
			else
				run = $urandom_range(8, 260);
			if (run > left)
				run = left;
			repeat (run) key_pending.push_back(k);
			left -= run;
			k = !k;
		end
	endtask

	initial begin
		longint unsigned x, x2, term, pos, neg, s, e;
		int idle_mode [4][2];
		idle_mode = '{'{0, 0}, '{83, 0}, '{0, 83}, '{6, 6}};

		// quarter-wave table: Q30 Taylor series, rounded half up, capped
		for (int i = 0; i < TABLE_LEN; i++) begin
			x = (HALF_PI * (2 * i + 1)) / (2 * TABLE_LEN);
			x2 = (x * x) >> 30;
			term = x;
			pos = x;
			neg = 0;
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					neg += term;
				else
					pos += term;
			end
			s = (pos > neg) ? pos - neg : 0;
			e = (s * TONE_MAX + (64'd1 << 29)) >> 30;
			sine_rom[i] = (e > TONE_MAX) ? TONE_MAX : 32'(e);
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// silent ticks, attack and decay at the reset settings
		push_keys(6'b001110, 6);
		settle();
		// full-scale clamp, one-tick ramp, all four quadrants near the peak
		write_reg(REG_PHASE_STEP, 32'h3FF0_0000);
		write_reg(REG_VOLUME, 32'hFFFF_FFFF);
		write_reg(REG_RAMP_STEP, 32'hFFFF_FFFF);
		push_keys(6'b111110, 6);
		settle();
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_VOLUME, 32'hABCD_8000);
		write_reg(REG_RAMP_STEP, 32'd300);
		push_keys(2'b11, 2);
		settle();
		// frozen amplitude; a write to the unused index changes nothing
		write_reg(REG_RAMP_STEP, 32'd0);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		push_keys(2'b10, 2);
		settle();
		write_reg(REG_VOLUME, 32'd0);
		write_reg(REG_RAMP_STEP, 32'd1);
		push_keys(2'b11, 2);
		settle();
		write_reg(REG_PHASE_STEP, 32'd0);
		write_reg(REG_RAMP_STEP, 32'd32768);
		write_reg(REG_VOLUME, 32'd1);
		push_keys(3'b110, 3);
		settle();

		for (int p = 0; p < 8; p++) begin
			shuffle_config();
			sender_idle_pct = idle_mode[p % 4][0];
			sink_stall_pct = idle_mode[p % 4][1];
			queue_keys(225);
			settle();
		end

		if (mismatch_cnt == 0 && tone_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
